>>> rtl/hca_pkg.sv
// ----------------------------------------------------------------------------
// hca_pkg
// Shared types, register codes and small arithmetic helpers for the HSL
// color adjust pipeline.
// ----------------------------------------------------------------------------
package hca_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL = 1'd1;

  // code 3 is unused and behaves as pastel
  typedef enum logic [1:0] {
    MODE_LIGHTEN  = 2'd0,
    MODE_SATURATE = 2'd1,
    MODE_PASTEL   = 2'd2
  } mode_t;

  localparam logic signed [7:0] LEVEL_MAX = 8'sd100;
  localparam logic signed [7:0] LEVEL_MIN = -8'sd100;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] lt;
  } hsl_t;

  // floor(x / 100) for x below 25600
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [34:0] p;
    p = 35'(x) * 35'(5243);
    return p[26:19];
  endfunction

  // t / 100 truncating toward zero, |t| <= 10000
  function automatic logic signed [8:0] div100_trunc(input logic signed [15:0] t);
    logic [15:0] mag;
    logic [7:0]  q;
    mag = t[15] ? 16'(-t) : 16'(t);
    q   = div100(mag[14:0]);
    return t[15] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic logic [6:0] clamp_pct(input logic signed [9:0] x);
    if (x > 10'sd100) begin
      return 7'd100;
    end else if (x < 10'sd0) begin
      return 7'd0;
    end
    return x[6:0];
  endfunction

endpackage

>>> rtl/hca_div.sv
// ----------------------------------------------------------------------------
// hca_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// word that travels alongside the operands.
// ----------------------------------------------------------------------------
module hca_div #(
  parameter int NUM_W  = 24,
  parameter int DEN_W  = 9,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quot,
  output logic [SIDE_W-1:0] side_out
);

  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  nq_r   [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];
  logic              vld_r  [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_src;
    logic              vld_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    if (i == 0) begin : g_first
      assign rem_in   = '0;
      assign nq_in    = num;
      assign den_in   = den;
      assign side_src = side_in;
      assign vld_in   = in_valid;
    end else begin : g_next
      assign rem_in   = rem_r[i-1];
      assign nq_in    = nq_r[i-1];
      assign den_in   = den_r[i-1];
      assign side_src = side_r[i-1];
      assign vld_in   = vld_r[i-1];
    end

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_r[i]   <= {nq_in[NUM_W-2:0], fits};
        den_r[i]  <= den_in;
        side_r[i] <= side_src;
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign quot      = nq_r[NUM_W-1];
  assign side_out  = side_r[NUM_W-1];

endmodule

>>> rtl/hca_rgb2hsl.sv
// ----------------------------------------------------------------------------
// hca_rgb2hsl
// Fixed-point RGB to HSL conversion: min/max and hue sextant select, then a
// saturation divide and a hue divide through two divider pipelines.
// ----------------------------------------------------------------------------
module hca_rgb2hsl import hca_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  pix_in_t in_data,
  output logic    hsl_valid,
  output hsl_t    hsl
);

  typedef struct packed {
    logic [7:0] diff;
    logic [7:0] vm;
    logic [8:0] base;
    logic       neg;
    logic       nz;
    logic [6:0] lt;
  } sat_side_t;

  typedef struct packed {
    logic [8:0] base;
    logic       neg;
    logic       nz;
    logic [6:0] lt;
    logic [6:0] sat;
  } hue_side_t;

  logic [7:0]  r, g, b, vmax, vmin, vm, dsel;
  logic [8:0]  sum, den, base;
  logic        neg, nz;
  logic [22:0] lp;

  sat_side_t   s1_in, s1_out;
  hue_side_t   s2_in, s2_out;
  logic [23:0] q1, q2;
  logic        v1, v2;
  logic [23:0] sp;
  logic [22:0] dp;
  logic [9:0]  hue_sum;
  logic [8:0]  hue_next;

  assign r = in_data.in_red;
  assign g = in_data.in_green;
  assign b = in_data.in_blue;

  always_comb begin
    vmax = r;
    if (g > vmax) vmax = g;
    if (b > vmax) vmax = b;
    vmin = r;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    sum = 9'(vmax) + 9'(vmin);
    vm  = vmax - vmin;
    // light colors divide by the distance to full scale
    den = sum[8] ? 9'(10'd512 - 10'(sum)) : sum;
    nz  = (sum != 9'd0) && (vm != 8'd0);
    lp  = 23'(sum) * 23'(12800);
    if (r == vmax) begin
      if (g == vmin) begin
        base = 9'd300; neg = 1'b0; dsel = vmax - b;
      end else begin
        base = 9'd60;  neg = 1'b1; dsel = vmax - g;
      end
    end else if (g == vmax) begin
      if (b == vmin) begin
        base = 9'd60;  neg = 1'b0; dsel = vmax - r;
      end else begin
        base = 9'd180; neg = 1'b1; dsel = vmax - b;
      end
    end else begin
      if (r == vmin) begin
        base = 9'd180; neg = 1'b0; dsel = vmax - g;
      end else begin
        base = 9'd300; neg = 1'b1; dsel = vmax - r;
      end
    end
  end

  assign s1_in = '{diff: dsel, vm: vm, base: base, neg: neg, nz: nz, lt: lp[22:16]};

  hca_div #(.NUM_W(24), .DEN_W(9), .SIDE_W($bits(sat_side_t))) u_div_sat (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .num      ({vm, 16'h0000}),
    .den      (den),
    .side_in  (s1_in),
    .out_valid(v1),
    .quot     (q1),
    .side_out (s1_out)
  );

  assign sp    = 24'(q1[16:0]) * 24'(100);
  assign s2_in = '{base: s1_out.base, neg: s1_out.neg, nz: s1_out.nz, lt: s1_out.lt,
                   sat: s1_out.nz ? sp[22:16] : 7'd0};

  hca_div #(.NUM_W(24), .DEN_W(8), .SIDE_W($bits(hue_side_t))) u_div_hue (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v1),
    .num      ({s1_out.diff, 16'h0000}),
    .den      (s1_out.vm),
    .side_in  (s2_in),
    .out_valid(v2),
    .quot     (q2),
    .side_out (s2_out)
  );

  always_comb begin
    dp      = 23'(q2[16:0]) * 23'(60);
    hue_sum = s2_out.neg ? 10'(s2_out.base) - 10'(dp[22:16])
                         : 10'(s2_out.base) + 10'(dp[22:16]);
    // full turn wraps to zero
    if (!s2_out.nz || hue_sum == 10'd360) begin
      hue_next = 9'd0;
    end else begin
      hue_next = hue_sum[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsl_valid <= 1'b0;
    end else if (en) begin
      hsl_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsl <= '{hue: hue_next, sat: s2_out.sat, lt: s2_out.lt};
    end
  end

endmodule

>>> rtl/hca_hsl2rgb.sv
// ----------------------------------------------------------------------------
// hca_hsl2rgb
// Applies the lighten / saturate adjustment, then converts HSL back to 8-bit
// RGB with the integer sextant method.
// ----------------------------------------------------------------------------
module hca_hsl2rgb import hca_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             hsl_valid,
  input  hsl_t             hsl,
  input  logic [1:0]       adjust_mode,
  input  logic signed [7:0] adjust_level,
  output logic             out_valid,
  output pix_out_t         out_data
);

  typedef struct packed {
    logic [6:0] v;
    logic [8:0] m;
    logic [6:0] fract;
    logic [2:0] sext;
  } sv_side_t;

  // stage a1: adjustment products
  logic                va1;
  logic signed [15:0]  tl, ts;
  hsl_t                ha1;
  // stage a2: adjusted values
  logic                va2;
  logic [8:0]          ha2;
  logic [6:0]          sa2, la2;
  // stage b1
  logic                vb1, lo_b1;
  logic [13:0]         p_b1;
  logic [6:0]          s_b1, l_b1;
  logic [8:0]          h_b1;
  logic [2:0]          sext_b1;
  // stage b2
  logic                vb2;
  logic [6:0]          v_b2;
  logic signed [8:0]   m_b2;
  logic [5:0]          rem_b2;
  logic [2:0]          sext_b2;
  // divider and later stages
  sv_side_t            sd_in, sd_out;
  logic [13:0]         sv_q;
  logic                vdv;
  logic                vd, ve, vf, vg;
  logic [13:0]         p1_d;
  logic [20:0]         p2_e;
  logic [6:0]          vsf_f;
  sv_side_t            sd_d, sd_e, sd_f;
  logic [14:0]         c0_g, c1_g, c2_g;

  logic signed [15:0]  dlx, dsx, lvx;
  logic signed [9:0]   lsum, ssum;
  logic [19:0]         hx;
  logic [7:0]          vq;
  logic [7:0]          vsum;
  logic [6:0]          v_next;
  logic [8:0]          rem_w;
  logic [22:0]         fp;
  logic signed [9:0]   vmd;
  logic [13:0]         sv_num;
  logic [41:0]         vp;
  logic signed [9:0]   vs, ms, up, dn, c0s, c1s, c2s;

  // ---- stage a1
  always_comb begin
    lvx = 16'(adjust_level);
    dlx = $signed(16'(8'd100 - 8'(hsl.lt)));
    dsx = $signed(16'(8'd100 - 8'(hsl.sat)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tl  <= dlx * lvx;
      ts  <= dsx * lvx;
      ha1 <= hsl;
    end
  end

  // ---- stage a2
  always_comb begin
    lsum = $signed({3'b000, ha1.lt}) + 10'(div100_trunc(tl));
    ssum = $signed({3'b000, ha1.sat}) - 10'(div100_trunc(ts));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ha2 <= ha1.hue;
      la2 <= (adjust_mode != MODE_SATURATE) ? clamp_pct(lsum) : ha1.lt;
      sa2 <= (adjust_mode != MODE_LIGHTEN)  ? clamp_pct(ssum) : ha1.sat;
    end
  end

  // ---- stage b1
  assign hx = 20'(ha2) * 20'(1093);

  always_ff @(posedge clk) begin
    if (en) begin
      lo_b1   <= la2 < 7'd50;
      p_b1    <= (la2 < 7'd50) ? 14'(la2) * (14'(sa2) + 14'd100) : 14'(la2) * 14'(sa2);
      s_b1    <= sa2;
      l_b1    <= la2;
      h_b1    <= ha2;
      sext_b1 <= hx[18:16];
    end
  end

  // ---- stage b2
  always_comb begin
    vq     = div100({1'b0, p_b1});
    vsum   = 8'(l_b1) + 8'(s_b1) - vq;
    v_next = lo_b1 ? vq[6:0] : vsum[6:0];
    rem_w  = h_b1 - 9'(sext_b1) * 9'd60;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_b2    <= v_next;
      m_b2    <= $signed({1'b0, l_b1, 1'b0}) - $signed({2'b00, v_next});
      rem_b2  <= rem_w[5:0];
      sext_b2 <= sext_b1;
    end
  end

  // ---- spread divide: 100*(v-m)/v
  always_comb begin
    fp     = 23'(rem_b2) * 23'(109300);
    vmd    = $signed({3'b000, v_b2}) - 10'(m_b2);
    sv_num = 14'(vmd[7:0]) * 14'd100;
    sd_in  = '{v: v_b2, m: m_b2, fract: fp[22:16], sext: sext_b2};
  end

  hca_div #(.NUM_W(14), .DEN_W(7), .SIDE_W($bits(sv_side_t))) u_div_sv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vb2),
    .num      (sv_num),
    .den      (v_b2),
    .side_in  (sd_in),
    .out_valid(vdv),
    .quot     (sv_q),
    .side_out (sd_out)
  );

  // ---- stages d, e, f: v*sv*fract/10000
  assign vp = 42'(p2_e) * 42'(1717987);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_d  <= 14'(sd_out.v) * 14'(sv_q[6:0]);
      sd_d  <= sd_out;
      p2_e  <= 21'(p1_d) * 21'(sd_d.fract);
      sd_e  <= sd_d;
      vsf_f <= vp[40:34];
      sd_f  <= sd_e;
    end
  end

  // ---- stage g: sextant select
  always_comb begin
    vs  = $signed({3'b000, sd_f.v});
    ms  = 10'(sd_f.m);
    up  = ms + $signed({3'b000, vsf_f});
    dn  = vs - $signed({3'b000, vsf_f});
    case (sd_f.sext)
      3'd0:    begin c0s = vs; c1s = up; c2s = ms; end
      3'd1:    begin c0s = dn; c1s = vs; c2s = ms; end
      3'd2:    begin c0s = ms; c1s = vs; c2s = up; end
      3'd3:    begin c0s = ms; c1s = dn; c2s = vs; end
      3'd4:    begin c0s = up; c1s = ms; c2s = vs; end
      default: begin c0s = vs; c1s = ms; c2s = dn; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // zero value gives black
      c0_g <= (sd_f.v == 7'd0) ? 15'd0 : 15'(clamp_pct(c0s)) * 15'd255;
      c1_g <= (sd_f.v == 7'd0) ? 15'd0 : 15'(clamp_pct(c1s)) * 15'd255;
      c2_g <= (sd_f.v == 7'd0) ? 15'd0 : 15'(clamp_pct(c2s)) * 15'd255;
    end
  end

  // ---- stage h: output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= '{out_red: div100(c0_g), out_green: div100(c1_g),
                    out_blue: div100(c2_g), out_alpha: 8'hFF};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va1       <= 1'b0;
      va2       <= 1'b0;
      vb1       <= 1'b0;
      vb2       <= 1'b0;
      vd        <= 1'b0;
      ve        <= 1'b0;
      vf        <= 1'b0;
      vg        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va1       <= hsl_valid;
      va2       <= va1;
      vb1       <= va2;
      vb2       <= vb1;
      vd        <= vdv;
      ve        <= vd;
      vf        <= ve;
      vg        <= vf;
      out_valid <= vg;
    end
  end

endmodule

>>> rtl/hsl_color_adjust_core.sv
// ----------------------------------------------------------------------------
// hsl_color_adjust_core
// Per-pixel lightness / saturation adjustment in integer HSL space.
// ----------------------------------------------------------------------------
//   channel   direction  handshake           payload
//   in        sink       in_valid/in_stall   pix_in_t  (rgb)
//   out       source     out_valid/out_stall pix_out_t (rgba, alpha 255)
//   cfg       sink       cfg_write           cfg_index, cfg_data
//
// one pixel per clock sustained while out_stall does not hold the pipeline; the depth
// comes from the three bit-per-stage dividers (saturation 24, hue 24, spread 14) plus
// the fixed-point stages around them.
// rst is synchronous and clears all valid bits and both registers.
// the whole pipeline holds while a result waits under out_stall.
// ----------------------------------------------------------------------------
module hsl_color_adjust_core import hca_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pix_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pix_out_t              out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic              en;
  logic [1:0]        adjust_mode;
  logic signed [7:0] adjust_level;
  logic signed [7:0] level_wr;
  logic              hsl_valid;
  hsl_t              hsl;

  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;
  assign level_wr = $signed(cfg_data[7:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      adjust_mode  <= MODE_LIGHTEN;
      adjust_level <= 8'sd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE: begin
          adjust_mode <= cfg_data[1:0];
        end
        REG_LEVEL: begin
          if (level_wr > LEVEL_MAX) begin
            adjust_level <= LEVEL_MAX;
          end else if (level_wr < LEVEL_MIN) begin
            adjust_level <= LEVEL_MIN;
          end else begin
            adjust_level <= level_wr;
          end
        end
        default: begin
        end
      endcase
    end
  end

  hca_rgb2hsl u_rgb2hsl (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .hsl_valid(hsl_valid),
    .hsl      (hsl)
  );

  hca_hsl2rgb u_hsl2rgb (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .hsl_valid   (hsl_valid),
    .hsl         (hsl),
    .adjust_mode (adjust_mode),
    .adjust_level(adjust_level),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

>>> rtl/hca_checker.sv
// ----------------------------------------------------------------------------
// hca_checker
// Port-level checks for the HSL color adjust core.
// ----------------------------------------------------------------------------
module hca_checker import hca_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input pix_out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.out_alpha == 8'hFF)
    else $error("alpha not opaque");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule

bind hsl_color_adjust_core hca_checker u_checker (.*);

>>> verif/hsl_color_adjust_checker.sv
// ----------------------------------------------------------------------------
// hsl_color_adjust_checker
// Watches the pixel channels and the register port, predicts each adjusted
// pixel in integer HSL arithmetic and compares it field by field.
// ----------------------------------------------------------------------------
module hsl_color_adjust_checker import hca_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  pix_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  pix_out_t              out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [1:0] cur_mode;
  int         cur_level;
  pix_out_t   pixel_queue[$];

  function automatic int pct_clamp(input int x);
    if (x > 100) return 100;
    if (x < 0) return 0;
    return x;
  endfunction

  function automatic int trunc100(input int x);
    if (x < 0) return -((-x) / 100);
    return x / 100;
  endfunction

  function automatic pix_out_t adjust_pixel(input pix_in_t p, input logic [1:0] md,
                                            input int lvl);
    longint r, g, b, v, m, lt, sat, hue, vm, den, rd, gd, bd;
    int h, s, l, vv, mm, sv, sext, fr, vsf, up, dn;
    int c[3];
    pix_out_t o;
    r = longint'(p.in_red) << 8;
    g = longint'(p.in_green) << 8;
    b = longint'(p.in_blue) << 8;
    v = r; m = r; sat = 0; hue = 0;
    if (g > v) v = g;
    if (b > v) v = b;
    if (g < m) m = g;
    if (b < m) m = b;
    lt = (v + m) / 2;
    if (lt != 0 && v != m) begin
      vm = v - m;
      den = (lt < 32768) ? (v + m) : (131072 - v - m);
      sat = (vm << 16) / den;
      rd = ((((v - r) << 16) / vm) * 60) >> 16;
      gd = ((((v - g) << 16) / vm) * 60) >> 16;
      bd = ((((v - b) << 16) / vm) * 60) >> 16;
      if (r == v) hue = (g == m) ? 300 + bd : 60 - gd;
      else if (g == v) hue = (b == m) ? 60 + rd : 180 - bd;
      else hue = (r == m) ? 180 + gd : 300 - rd;
    end
    h = int'(hue % 360);
    s = int'((sat * 100) >> 16);
    l = int'((lt * 100) >> 16);
    if (md != MODE_SATURATE) l = pct_clamp(l + trunc100((100 - l) * lvl));
    if (md != MODE_LIGHTEN) s = pct_clamp(s - trunc100((100 - s) * lvl));
    c = '{0, 0, 0};
    vv = (l < 50) ? (l * (s + 100) / 100) : (l + s - (l * s / 100));
    if (vv > 0) begin
      mm = l + l - vv;
      sv = 100 * (vv - mm) / vv;
      sext = h / 60;
      fr = 100 * (h - sext * 60) / 60;
      vsf = vv * sv * fr / 10000;
      up = mm + vsf;
      dn = vv - vsf;
      case (sext)
        0: c = '{vv, up, mm};
        1: c = '{dn, vv, mm};
        2: c = '{mm, vv, up};
        3: c = '{mm, dn, vv};
        4: c = '{up, mm, vv};
        default: c = '{vv, mm, dn};
      endcase
      for (int i = 0; i < 3; i++) c[i] = pct_clamp(c[i]) * 255 / 100;
    end
    o.out_red = c[0][7:0];
    o.out_green = c[1][7:0];
    o.out_blue = c[2][7:0];
    o.out_alpha = 8'd255;
    return o;
  endfunction

  assign pending = pixel_queue.size();

  always @(posedge clk) begin
    int lv;
    pix_out_t exp_pix;
    if (rst) begin
      cur_mode <= MODE_LIGHTEN;
      cur_level <= 0;
      pixel_queue.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_MODE) begin
          cur_mode <= cfg_data[1:0];
        end else begin
          lv = int'($signed(cfg_data));
          cur_level <= (lv > 100) ? 100 : (lv < -100) ? -100 : lv;
        end
      end
      if (in_valid && !in_stall) begin
        pixel_queue.push_back(adjust_pixel(in_data, cur_mode, cur_level));
      end
      if (out_valid && !out_stall) begin
        if (pixel_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected pixel %h", out_data);
        end else begin
          exp_pix = pixel_queue.pop_front();
          if (exp_pix !== out_data) begin
            fail_count++;
            if (fail_count <= 10)
              $display("pixel mismatch: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
                       exp_pix.out_red, exp_pix.out_green, exp_pix.out_blue,
                       exp_pix.out_alpha, out_data.out_red, out_data.out_green,
                       out_data.out_blue, out_data.out_alpha);
          end
        end
      end
    end
  end

  initial fail_count = 0;
endmodule

>>> verif/hsl_color_adjust_core_tb.sv
// ----------------------------------------------------------------------------
// hsl_color_adjust_core_tb
// Drives directed and random pixels through every mode code, a list of levels and
// random levels, with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module hsl_color_adjust_core_tb import hca_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 72;
  localparam int WATCHDOG_LIMIT = 5000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pix_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pix_out_t              out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;
  int                    send_idle_pct = 31;
  int                    recv_idle_pct = 64;
  int                    idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hsl_color_adjust_core dut (.*);

  hsl_color_adjust_checker chk (.*);

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("hsl_color_adjust_core verification failed");
      $finish;
    end
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_red: r, in_green: g, in_blue: b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_pixels(input int count);
    int kind;
    logic [7:0] a;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      a = 8'($urandom);
      // greys and pixels with green at 0 or 255 now and then
      if (kind == 0) send_pixel(a, a, a);
      else if (kind == 1) send_pixel(a, ($urandom_range(1)) ? 8'd0 : 8'd255, 8'($urandom));
      else send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // mode, level pairs swept between random blocks
  logic [1:0] mode_list[8] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd2};
  logic [7:0] level_list[8] = '{8'd100, 8'h9c, 8'd0, 8'd127, 8'h80, 8'd37, 8'hd3, 8'd101};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed part, reset settings then extremes
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    drain_pipe();
    write_reg(REG_MODE, 8'(MODE_PASTEL));
    write_reg(REG_LEVEL, 8'd50);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd10, 8'd20, 8'd250);
    send_pixel(8'd170, 8'd85, 8'd85);
    send_pixel(8'd1, 8'd0, 8'd0);
    drain_pipe();
    write_reg(REG_LEVEL, 8'h80);
    send_pixel(8'd255, 8'd128, 8'd0);
    send_pixel(8'd64, 8'd64, 8'd64);
    send_pixel(8'd255, 8'd254, 8'd1);
    drain_pipe();
    send_idle_pct = 31;
    recv_idle_pct = 64;
    for (int k = 0; k < 8; k++) begin
      if (k == 3) begin
        send_idle_pct = 64;
        recv_idle_pct = 31;
      end else if (k == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_MODE, 8'(mode_list[k]));
      write_reg(REG_LEVEL, level_list[k]);
      random_pixels(120);
      // hold until the pipe empties, then a random level in the same mode
      drain_pipe();
      write_reg(REG_LEVEL, 8'($urandom));
      random_pixels(50);
      drain_pipe();
    end
    if (fail_count == 0) begin
      $display("hsl_color_adjust_core verification clean");
    end else begin
      $display("hsl_color_adjust_core verification failed");
    end
    $finish;
  end
endmodule
